>>> rtl/assert_macros.svh
// Assertion macros for the RTL, included by value_noise_3d_trilinear.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define VN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define VN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/vn3_pkg.sv
// Package for the 3-D value noise block: sizes, codes, shared types and helpers.
// Depends on nothing.
package vn3_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int FRAC_BITS  = 16;
  localparam int PERM_W     = 8;
  localparam int VAL_W      = 16;
  localparam int COORD_W    = 32;
  localparam int NUM_CORNER = 8;
  localparam int NUM_BANK   = NUM_CORNER / 2;

  localparam int FRAC_RS = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int FRAC_LS = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    TSEL_RAND = 2'd0,
    TSEL_PX   = 2'd1,
    TSEL_PY   = 2'd2,
    TSEL_PZ   = 2'd3
  } tsel_t;

  typedef struct packed {
    logic              we;
    logic [1:0]        sel;
    logic [ADDR_W-1:0] idx;
    logic [VAL_W-1:0]  val;
  } tbl_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] x;
    logic [ADDR_W-1:0] y;
    logic [ADDR_W-1:0] z;
  } cell_t;

  // Floor cell of a signed fixed-point coordinate, reduced to a table index.
  function automatic logic [ADDR_W-1:0] cell_of(input logic [COORD_W-1:0] raw);
    logic signed [COORD_W-1:0] sh;
    sh = $signed(raw) >>> FRAC_BITS;
    return sh[ADDR_W-1:0];
  endfunction

  // Fraction of a coordinate brought to Q0.16.
  function automatic logic [15:0] frac_of(input logic [COORD_W-1:0] raw);
    logic [COORD_W-1:0] f;
    f = raw & ((COORD_W'(1) << FRAC_BITS) - COORD_W'(1));
    f = (f >> FRAC_RS) << FRAC_LS;
    return f[15:0];
  endfunction

endpackage

>>> rtl/vn3_if.sv
// Handshake channels of the 3-D value noise block: input items and results.
// Depends on vn3_pkg.
interface vn3_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [1:0]                     table_select;
  logic [7:0]                     entry_index;
  logic [vn3_pkg::VAL_W-1:0]      entry_value;
  logic signed [vn3_pkg::COORD_W-1:0] point_x;
  logic signed [vn3_pkg::COORD_W-1:0] point_y;
  logic signed [vn3_pkg::COORD_W-1:0] point_z;

  modport source (output valid, opcode, table_select, entry_index, entry_value,
                  point_x, point_y, point_z, input ready);
  modport sink (input valid, opcode, table_select, entry_index, entry_value,
                point_x, point_y, point_z, output ready);
endinterface

interface vn3_out_if;
  logic                      valid;
  logic                      ready;
  logic [vn3_pkg::VAL_W-1:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

>>> rtl/vn3_tables.sv
// Table storage of the noise block: three permutation memories and four
// replicated banks of random values, with the corner hash between them.
// Depends on vn3_pkg.
module vn3_tables (
  input  logic                  clk,
  input  logic                  en,
  input  vn3_pkg::tbl_wr_t      wr,
  input  vn3_pkg::cell_t        pt_cell,
  output logic [vn3_pkg::VAL_W-1:0] rv_q [vn3_pkg::NUM_CORNER]
);

  logic [vn3_pkg::PERM_W-1:0] perm_x [vn3_pkg::TABLE_SIZE];
  logic [vn3_pkg::PERM_W-1:0] perm_y [vn3_pkg::TABLE_SIZE];
  logic [vn3_pkg::PERM_W-1:0] perm_z [vn3_pkg::TABLE_SIZE];
  // Every bank holds the same contents, so eight corners read at once.
  logic [vn3_pkg::VAL_W-1:0]  rv_mem [vn3_pkg::NUM_BANK][vn3_pkg::TABLE_SIZE];

  logic [vn3_pkg::ADDR_W-1:0] x1, y1, z1;
  logic [vn3_pkg::PERM_W-1:0] px_r [2];
  logic [vn3_pkg::PERM_W-1:0] py_r [2];
  logic [vn3_pkg::PERM_W-1:0] pz_r [2];
  logic [vn3_pkg::ADDR_W-1:0] hidx [vn3_pkg::NUM_CORNER];

  assign x1 = pt_cell.x + 1'b1;
  assign y1 = pt_cell.y + 1'b1;
  assign z1 = pt_cell.z + 1'b1;

  always_ff @(posedge clk) begin
    if (wr.we && wr.sel == vn3_pkg::TSEL_PX) perm_x[wr.idx] <= wr.val[vn3_pkg::PERM_W-1:0];
    if (wr.we && wr.sel == vn3_pkg::TSEL_PY) perm_y[wr.idx] <= wr.val[vn3_pkg::PERM_W-1:0];
    if (wr.we && wr.sel == vn3_pkg::TSEL_PZ) perm_z[wr.idx] <= wr.val[vn3_pkg::PERM_W-1:0];
    if (en) begin
      px_r[0] <= perm_x[pt_cell.x];
      px_r[1] <= perm_x[x1];
      py_r[0] <= perm_y[pt_cell.y];
      py_r[1] <= perm_y[y1];
      pz_r[0] <= perm_z[pt_cell.z];
      pz_r[1] <= perm_z[z1];
    end
  end

  // Corner order is x offset, then y, then z, most significant first.
  always_comb begin
    for (int c = 0; c < vn3_pkg::NUM_CORNER; c++) begin
      hidx[c] = vn3_pkg::ADDR_W'(px_r[c[2]] ^ py_r[c[1]] ^ pz_r[c[0]]);
    end
  end

  // A read and a write to the same entry in the same cycle return the old
  // value, which is the order items arrive in.
  always_ff @(posedge clk) begin
    for (int b = 0; b < vn3_pkg::NUM_BANK; b++) begin
      if (wr.we && wr.sel == vn3_pkg::TSEL_RAND) rv_mem[b][wr.idx] <= wr.val;
      if (en) begin
        rv_q[2*b]   <= rv_mem[b][hidx[2*b]];
        rv_q[2*b+1] <= rv_mem[b][hidx[2*b+1]];
      end
    end
  end

endmodule

>>> rtl/value_noise_3d_trilinear.sv
// 3-D value noise with smoothstep-weighted trilinear blend.
// One item per cycle, while the output register is empty or being taken.
// Load items write the tables at their accept edge and give no result.
// The pipeline advances whenever the output register is empty or being taken.
// Reset clears the valid bits only; table contents stay undefined until loaded.
// Depends on vn3_pkg, vn3_if, vn3_tables and assert_macros.svh.
`include "assert_macros.svh"
module value_noise_3d_trilinear (
  input logic clk,
  input logic rst_n,
  vn3_in_if.sink    in_ch,
  vn3_out_if.source out_ch
);

  logic                          en;
  logic                          acc;
  logic [6:1]                    vld_r;
  logic [6:1]                    vld_nxt;
  logic                          out_valid_r;
  logic [vn3_pkg::VAL_W-1:0]     out_noise_r;
  vn3_pkg::tbl_wr_t              wr;
  vn3_pkg::cell_t                pt_cell;
  logic [vn3_pkg::VAL_W-1:0]     rv_q [vn3_pkg::NUM_CORNER];

  logic [15:0] fr [3];
  logic [31:0] sq_r [3];
  logic [17:0] tt_r [3];
  logic [15:0] s_r [3];
  logic [16:0] wx [2], wy [2], wz [2];
  logic [32:0] wxy_r [4];
  logic [16:0] wz_r [2];
  logic [vn3_pkg::VAL_W-1:0] rv3_r [vn3_pkg::NUM_CORNER];
  logic [vn3_pkg::VAL_W-1:0] rv4_r [vn3_pkg::NUM_CORNER];
  logic [48:0] wxyz_r [vn3_pkg::NUM_CORNER];
  logic [40:0] lo_r [vn3_pkg::NUM_CORNER];
  logic [39:0] hi_r [vn3_pkg::NUM_CORNER];
  logic [63:0] prod [vn3_pkg::NUM_CORNER];
  logic [63:0] psum_r [4];
  logic [63:0] total;

  assign en  = !out_valid_r || out_ch.ready;
  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = en && rst_n;

  assign wr.we  = acc && (in_ch.opcode == vn3_pkg::OP_LOAD);
  assign wr.sel = in_ch.table_select;
  assign wr.idx = vn3_pkg::ADDR_W'(in_ch.entry_index);
  assign wr.val = in_ch.entry_value;

  assign pt_cell.x = vn3_pkg::cell_of(in_ch.point_x);
  assign pt_cell.y = vn3_pkg::cell_of(in_ch.point_y);
  assign pt_cell.z = vn3_pkg::cell_of(in_ch.point_z);

  assign fr[0] = vn3_pkg::frac_of(in_ch.point_x);
  assign fr[1] = vn3_pkg::frac_of(in_ch.point_y);
  assign fr[2] = vn3_pkg::frac_of(in_ch.point_z);

  vn3_tables u_tables (
    .clk     (clk),
    .en      (en),
    .wr      (wr),
    .pt_cell (pt_cell),
    .rv_q    (rv_q)
  );

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      wx[i] = i[0] ? {1'b0, s_r[0]} : 17'h10000 - {1'b0, s_r[0]};
      wy[i] = i[0] ? {1'b0, s_r[1]} : 17'h10000 - {1'b0, s_r[1]};
      wz[i] = i[0] ? {1'b0, s_r[2]} : 17'h10000 - {1'b0, s_r[2]};
    end
    for (int c = 0; c < vn3_pkg::NUM_CORNER; c++) begin
      prod[c] = 64'(lo_r[c]) + (64'(hi_r[c]) << 25);
    end
    total = (psum_r[0] + psum_r[1]) + (psum_r[2] + psum_r[3]);
  end

  assign vld_nxt = {vld_r[5:1], acc && (in_ch.opcode == vn3_pkg::OP_EVAL)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[6];
    end
  end

  // Datapath: smoothstep, weight products, split products, adder tree.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        sq_r[a] <= 32'(fr[a]) * 32'(fr[a]);
        tt_r[a] <= 18'd196608 - 18'({fr[a], 1'b0});
        s_r[a]  <= 16'((50'(sq_r[a]) * 50'(tt_r[a])) >> 32);
      end
      for (int k = 0; k < 4; k++) begin
        wxy_r[k] <= 33'(wx[k[1]]) * 33'(wy[k[0]]);
      end
      wz_r[0] <= wz[0];
      wz_r[1] <= wz[1];
      for (int c = 0; c < vn3_pkg::NUM_CORNER; c++) begin
        rv3_r[c]  <= rv_q[c];
        rv4_r[c]  <= rv3_r[c];
        wxyz_r[c] <= 49'(wxy_r[c[2:1]]) * 49'(wz_r[c[0]]);
        lo_r[c]   <= 41'(wxyz_r[c][24:0]) * 41'(rv4_r[c]);
        hi_r[c]   <= 40'(wxyz_r[c][48:25]) * 40'(rv4_r[c]);
      end
      for (int k = 0; k < 4; k++) begin
        psum_r[k] <= prod[2*k] + prod[2*k+1];
      end
      if (vld_r[6]) out_noise_r <= total[63:48];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.noise_value = out_noise_r;

  `VN_ASSERT_NOW(a_ready_when_empty, !out_valid_r, in_ch.ready)
  `VN_ASSERT_NEXT(a_last_stage_to_out, en && vld_r[6], out_valid_r)
  `VN_ASSERT_NEXT(a_stall_freezes_pipe, !en, $stable(vld_r))
  `VN_ASSERT_NEXT(a_load_no_entry, acc && in_ch.opcode == vn3_pkg::OP_LOAD, !vld_r[1])

endmodule
